@@ rtl/core/tvrm_pkg.sv @@
// Shared constants and types for the two-voice resampling mixer.
// No dependencies; imported by every module of the block.
`default_nettype none
package tvrm_pkg;

	// clip memory geometry (CLIP_WORDS is a power of two, 16 to 65536)
	localparam int CLIP_WORDS = 4096;
	localparam int ADDR_W     = $clog2(CLIP_WORDS);

	// voice file
	localparam int VOICE_COUNT = 2;
	localparam int VIDX_W      = $clog2(VOICE_COUNT);

	// register reset values
	localparam logic [15:0] GAIN_RESET = 16'd11469;
	localparam logic [7:0]  FADE_RESET = 8'd80;

	// fade divider: magnitude of sample times fade count
	localparam int DIV_W     = 24;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	// command codes
	typedef enum logic [1:0] {
		CMD_LOAD    = 2'd0,
		CMD_TRIGGER = 2'd1,
		CMD_STOP    = 2'd2,
		CMD_RENDER  = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic CFG_GAIN = 1'b0;
	localparam logic CFG_FADE = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/tvrm_clip_mem.sv @@
// Clip sample memory: one write port, one read port, registered read data.
// Depends on tvrm_pkg for the depth and address width.
`default_nettype none
module tvrm_clip_mem
	import tvrm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [15:0]       wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [15:0]       rdata
);

	logic [15:0] mem [CLIP_WORDS];

	// write on load, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/tvrm_div.sv @@
// Restoring divider, one quotient bit per cycle, for the fade scaling.
// Depends on tvrm_pkg for the dividend width and counter width.
`default_nettype none
module tvrm_div
	import tvrm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [7:0]       divisor,
	output logic                  done,
	output logic      [DIV_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [7:0]           rem_q;
	logic [DIV_W-1:0]     quo_q;

	logic [8:0]       shifted;
	logic             ge;
	logic [7:0]       rem_n;
	logic [DIV_W-1:0] quo_n;

	// shift in the next dividend bit and try a subtract
	always_comb begin
		shifted = {rem_q, quo_q[DIV_W-1]};
		ge      = shifted >= {1'b0, divisor};
		rem_n   = ge ? 8'(shifted - {1'b0, divisor}) : shifted[7:0];
		quo_n   = {quo_q[DIV_W-2:0], ge};
	end

	// load on start, iterate while busy, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
				rem_q  <= '0;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= rem_n;
				quo_q <= quo_n;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still iterating");
`endif

endmodule
`default_nettype wire

@@ rtl/core/two_voice_resampling_mixer.sv @@
// Two-voice resampling mixer: load, trigger, stop are accepted while idle and keep busy low.
// Render: each playing voice takes two clip memory reads and an interpolation multiply,
// and each fading voice also goes through the bit-serial fade divider; then done pulses.
// One render at a time; receiver cannot stall.
// Reset: voices idle, gain 11469, fade length 80; clip memory undefined until loaded.
// Depends on tvrm_pkg, tvrm_clip_mem, tvrm_div.
`default_nettype none
module two_voice_resampling_mixer
	import tvrm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [11:0] sample_address,
	input  wire logic [15:0] sample_value,
	input  wire logic [11:0] clip_start,
	input  wire logic [12:0] clip_length,
	input  wire logic [17:0] step,
	output logic             done,
	output logic [15:0]      mixed_sample,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_RDA, S_RDB, S_LATB, S_MUL, S_SUM,
		S_FMUL, S_DSTART, S_DWAIT, S_ACCUM, S_GAIN, S_FIN
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] gain_q;
	logic [7:0]  fade_len_q;

	// voice file
	logic [11:0] base_q   [VOICE_COUNT];
	logic [12:0] length_q [VOICE_COUNT];
	logic [31:0] pos_q    [VOICE_COUNT];
	logic [17:0] step_q   [VOICE_COUNT];
	logic [8:0]  fade_q   [VOICE_COUNT];
	logic        active_q [VOICE_COUNT];

	// render datapath
	logic [VIDX_W-1:0]  v_q;
	logic signed [15:0] a_q;
	logic signed [15:0] b_q;
	logic signed [33:0] iprod_q;
	logic signed [16:0] s_q;
	logic signed [25:0] p_q;
	logic               neg_q;
	logic signed [24:0] contrib_q;
	logic signed [25:0] acc_q;
	logic signed [42:0] gprod_q;
	logic               done_q;
	logic [15:0]        mixed_q;

	// memory and divider hookup
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0]       mem_rdata;
	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [7:0]        div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quotient;

	// accept decode
	logic acc_load, acc_trig, acc_stop, acc_render;
	always_comb begin
		acc_load   = start && !busy && (cmd_t'(command) == CMD_LOAD);
		acc_trig   = start && !busy && (cmd_t'(command) == CMD_TRIGGER);
		acc_stop   = start && !busy && (cmd_t'(command) == CMD_STOP);
		acc_render = start && !busy && (cmd_t'(command) == CMD_RENDER);
	end

	// pick the highest idle voice, voice 0 if none
	logic [VIDX_W-1:0] slot;
	always_comb begin
		slot = '0;
		for (int i = 0; i < VOICE_COUNT; i++) begin
			if (!active_q[i]) begin
				slot = VIDX_W'(i);
			end
		end
	end

	// current voice taps and end check
	logic [15:0]       idx;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic              at_end;
	logic [8:0]        fade_dec;
	always_comb begin
		idx      = pos_q[v_q][31:16];
		addr_a   = ADDR_W'({5'b0, base_q[v_q]} + {1'b0, idx});
		addr_b   = ADDR_W'(addr_a + 1'b1);
		at_end   = ({1'b0, idx} + 17'd1) >= {4'b0, length_q[v_q]};
		fade_dec = fade_q[v_q] - 9'd1;
	end

	// output truncation toward zero and saturation
	logic signed [42:0] gadj;
	logic signed [26:0] gq;
	logic [15:0]        sat;
	always_comb begin
		gadj = gprod_q[42] ? (gprod_q + 43'sd65535) : gprod_q;
		gq   = gadj[42:16];
		if (gq > 27'sd32767) begin
			sat = 16'h7FFF;
		end else if (gq < -27'sd32768) begin
			sat = 16'h8000;
		end else begin
			sat = gq[15:0];
		end
	end

	assign mem_we       = acc_load;
	assign mem_waddr    = ADDR_W'({5'b0, sample_address});
	assign mem_raddr    = (state_q == S_RDB) ? addr_b : addr_a;
	assign div_start    = (state_q == S_DSTART);
	assign div_dividend = p_q[25] ? DIV_W'(-p_q) : DIV_W'(p_q);
	assign div_divisor  = (fade_len_q == 8'd0) ? 8'd1 : fade_len_q;

	tvrm_clip_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (sample_value),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tvrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// sequencer, voice file and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			gain_q     <= GAIN_RESET;
			fade_len_q <= FADE_RESET;
			for (int i = 0; i < VOICE_COUNT; i++) begin
				base_q[i]   <= '0;
				length_q[i] <= '0;
				pos_q[i]    <= '0;
				step_q[i]   <= '0;
				fade_q[i]   <= '1;
				active_q[i] <= 1'b0;
			end
			v_q       <= '0;
			a_q       <= '0;
			b_q       <= '0;
			iprod_q   <= '0;
			s_q       <= '0;
			p_q       <= '0;
			neg_q     <= 1'b0;
			contrib_q <= '0;
			acc_q     <= '0;
			gprod_q   <= '0;
			done_q    <= 1'b0;
			mixed_q   <= '0;
		end else begin
			done_q <= 1'b0;

			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_GAIN: gain_q     <= cfg_data;
					CFG_FADE: fade_len_q <= cfg_data[7:0];
					default:  gain_q     <= gain_q;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					// trigger: fade the others, then start the clip on the slot
					if (acc_trig) begin
						for (int i = 0; i < VOICE_COUNT; i++) begin
							if (active_q[i] && VIDX_W'(i) != slot && fade_q[i][8]) begin
								fade_q[i] <= {1'b0, fade_len_q};
							end
						end
						base_q[slot]   <= clip_start;
						length_q[slot] <= clip_length;
						pos_q[slot]    <= '0;
						step_q[slot]   <= step;
						fade_q[slot]   <= '1;
						active_q[slot] <= 1'b1;
					end
					// stop: fade every active voice not yet fading
					if (acc_stop) begin
						for (int i = 0; i < VOICE_COUNT; i++) begin
							if (active_q[i] && fade_q[i][8]) begin
								fade_q[i] <= {1'b0, fade_len_q};
							end
						end
					end
					if (acc_render) begin
						v_q     <= '0;
						acc_q   <= '0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					// skip idle voices, retire voices past the clip end
					if (!active_q[v_q] || at_end) begin
						if (active_q[v_q]) begin
							active_q[v_q] <= 1'b0;
						end
						if (v_q == VIDX_W'(VOICE_COUNT - 1)) begin
							state_q <= S_GAIN;
						end else begin
							v_q     <= v_q + 1'b1;
							state_q <= S_CHK;
						end
					end else begin
						state_q <= S_RDA;
					end
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: begin
					a_q     <= $signed(mem_rdata);
					state_q <= S_LATB;
				end
				S_LATB: begin
					b_q     <= $signed(mem_rdata);
					state_q <= S_MUL;
				end
				S_MUL: begin
					// interpolate as a + (b - a) * frac
					iprod_q <= ($signed({b_q[15], b_q}) - $signed({a_q[15], a_q}))
						* $signed({1'b0, pos_q[v_q][15:0]});
					state_q <= S_SUM;
				end
				S_SUM: begin
					s_q       <= 17'($signed({{2{a_q[15]}}, a_q}) + $signed(iprod_q[33:16]));
					contrib_q <= 25'($signed({{2{a_q[15]}}, a_q}) + $signed(iprod_q[33:16]));
					state_q   <= fade_q[v_q][8] ? S_ACCUM : S_FMUL;
				end
				S_FMUL: begin
					p_q     <= s_q * $signed(fade_q[v_q]);
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					neg_q   <= p_q[25];
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					// hold until the divider delivers, then restore the sign
					if (div_done) begin
						contrib_q <= neg_q ? -$signed({1'b0, div_quotient})
							: $signed({1'b0, div_quotient});
						state_q <= S_ACCUM;
					end
				end
				S_ACCUM: begin
					acc_q        <= acc_q + {contrib_q[24], contrib_q};
					pos_q[v_q]   <= pos_q[v_q] + {14'b0, step_q[v_q]};
					if (!fade_q[v_q][8]) begin
						fade_q[v_q] <= fade_dec;
						if (fade_dec[8] || fade_dec == 9'd0) begin
							active_q[v_q] <= 1'b0;
						end
					end
					if (v_q == VIDX_W'(VOICE_COUNT - 1)) begin
						state_q <= S_GAIN;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_CHK;
					end
				end
				S_GAIN: begin
					gprod_q <= acc_q * $signed({1'b0, gain_q});
					state_q <= S_FIN;
				end
				S_FIN: begin
					mixed_q <= sat;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign mixed_sample = mixed_q;
	// take register writes only with no command in flight or being accepted
	assign cfg_ready    = (state_q == S_IDLE) && !start;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a render is in flight");
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd_t'(command) != CMD_RENDER)) |=> !done)
		else $error("result strobe after a command that gives none");
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (cmd_t'(command) == CMD_RENDER)) |=> busy)
		else $error("render accepted but sequencer stayed idle");
`endif

endmodule
`default_nettype wire

@@ bench/tb_two_voice_resampling_mixer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for two_voice_resampling_mixer: directed and random commands,
// every render frame checked against a cycle-free prediction of the voice engine.
// Depends on tvrm_pkg and the mixer RTL only.
module tb_two_voice_resampling_mixer;
	import tvrm_pkg::*;

	localparam int ITEMS_PER_PHASE = 230;
	localparam int PHASES          = 6;
	localparam int SETTLE_CYCLES   = 16;
	localparam int STALL_LIMIT     = 2000;

	typedef struct {
		cmd_t        cmd;
		logic [11:0] addr;
		logic [15:0] value;
		logic [11:0] cstart;
		logic [12:0] clen;
		logic [17:0] stp;
	} mixer_cmd_t;

	// Voice engine prediction plus the queue of frames still to arrive
	class frame_scoreboard;
		logic signed [15:0] clip [CLIP_WORDS];
		bit                 loaded [CLIP_WORDS];
		logic [ADDR_W-1:0]  v_base [VOICE_COUNT];
		logic [12:0]        v_len [VOICE_COUNT];
		logic [31:0]        v_pos [VOICE_COUNT];
		logic [17:0]        v_step [VOICE_COUNT];
		int                 v_fade [VOICE_COUNT];
		bit                 v_on [VOICE_COUNT];
		logic [15:0]        gain;
		logic [7:0]         fade_len;
		logic [15:0]        expected_frames [$];
		int mismatches, frames, n_items, n_load, n_trig, n_stop, n_sat, n_faded, n_writes;

		function new();
			for (int v = 0; v < VOICE_COUNT; v++) begin
				v_base[v] = '0;
				v_len[v]  = '0;
				v_pos[v]  = '0;
				v_step[v] = '0;
				v_fade[v] = -1;
				v_on[v]   = 1'b0;
			end
			gain     = GAIN_RESET;
			fade_len = FADE_RESET;
		endfunction

		function void set_register(logic idx, logic [15:0] data);
			if (idx == CFG_GAIN) begin
				gain = data;
			end else begin
				fade_len = data[7:0];
			end
			n_writes++;
		endfunction

		// Return the first clip address the next render would read before it was loaded
		function int unloaded_tap();
			int unsigned idx;
			logic [ADDR_W-1:0] a;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				if (!v_on[v]) continue;
				idx = v_pos[v][31:16];
				if (idx + 1 >= v_len[v]) continue;
				for (int k = 0; k < 2; k++) begin
					a = v_base[v] + idx + k;
					if (!loaded[a]) return a;
				end
			end
			return -1;
		endfunction

		// Put every active voice other than keep that is not yet fading into its fade-out
		function void start_fades(int keep);
			for (int v = 0; v < VOICE_COUNT; v++)
				if (v_on[v] && v != keep && v_fade[v] < 0) v_fade[v] = fade_len;
		endfunction

		// Interpolate one voice, apply its fade, advance its position
		function int voice_sample(int v);
			int unsigned idx;
			longint frac_l, mix, p, dv;
			int s, t0, t1;
			logic [ADDR_W-1:0] a0, a1;
			idx = v_pos[v][31:16];
			if (idx + 1 >= v_len[v]) begin
				v_on[v] = 1'b0;
				return 0;
			end
			frac_l = v_pos[v][15:0];
			a0 = v_base[v] + idx;
			a1 = v_base[v] + idx + 1;
			t0 = clip[a0];
			t1 = clip[a1];
			mix = t0 * (65536 - frac_l) + t1 * frac_l;
			s = int'(mix >>> 16);
			if (v_fade[v] >= 0) begin
				dv = (fade_len == 0) ? 1 : fade_len;
				p = longint'(s) * v_fade[v];
				s = int'(p / dv);
				v_fade[v]--;
				if (v_fade[v] <= 0) begin
					v_on[v] = 1'b0;
					n_faded++;
				end
			end
			v_pos[v] += v_step[v];
			return s;
		endfunction

		// Sum the voices, scale by gain toward zero, saturate
		function logic [15:0] mix_frame();
			longint acc, prod, g;
			acc = 0;
			for (int v = 0; v < VOICE_COUNT; v++)
				if (v_on[v]) acc += voice_sample(v);
			g = gain;
			prod = acc * g;
			acc = prod / 65536;
			if (acc > 32767) begin
				acc = 32767;
				n_sat++;
			end else if (acc < -32768) begin
				acc = -32768;
				n_sat++;
			end
			return acc[15:0];
		endfunction

		function void take_command(mixer_cmd_t c);
			int slot;
			n_items++;
			case (c.cmd)
				CMD_LOAD: begin
					clip[c.addr]   = c.value;
					loaded[c.addr] = 1'b1;
					n_load++;
				end
				CMD_TRIGGER: begin
					slot = 0;
					for (int v = 0; v < VOICE_COUNT; v++)
						if (!v_on[v]) slot = v;
					start_fades(slot);
					v_base[slot] = c.cstart;
					v_len[slot]  = c.clen;
					v_pos[slot]  = '0;
					v_step[slot] = c.stp;
					v_fade[slot] = -1;
					v_on[slot]   = 1'b1;
					n_trig++;
				end
				CMD_STOP: begin
					start_fades(-1);
					n_stop++;
				end
				default: begin
					expected_frames.push_back(mix_frame());
				end
			endcase
		endfunction

		function void check_frame(logic [15:0] got);
			logic [15:0] want;
			if (expected_frames.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: frame %0d arrived with none pending", $time, got);
				mismatches++;
				return;
			end
			want = expected_frames.pop_front();
			frames++;
			if (got !== want) begin
				if (mismatches < 10)
					$display("%0t: frame %0d mixed_sample expected %0d got %0d", $time, frames,
						$signed(want), $signed(got));
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = CMD_LOAD;
	logic [11:0] sample_address = '0;
	logic [15:0] sample_value = '0;
	logic [11:0] clip_start = '0;
	logic [12:0] clip_length = '0;
	logic [17:0] step = '0;
	logic        done;
	logic [15:0] mixed_sample;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = CFG_GAIN;
	logic [15:0] cfg_data = '0;

	bit gaps_on = 1'b1;
	frame_scoreboard sb = new();

	two_voice_resampling_mixer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.sample_address(sample_address),
		.sample_value(sample_value),
		.clip_start(clip_start),
		.clip_length(clip_length),
		.step(step),
		.done(done),
		.mixed_sample(mixed_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Check each strobed frame at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done) sb.check_frame(mixed_sample);
	end

	// Abort when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
			else quiet++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// Present one item, hold it until accepted, then record it
	task automatic send_cmd(cmd_t c, logic [11:0] a, logic [15:0] v, logic [11:0] cs,
			logic [12:0] cl, logic [17:0] st);
		mixer_cmd_t it;
		it = '{cmd: c, addr: a, value: v, cstart: cs, clen: cl, stp: st};
		if (gaps_on && $urandom_range(99) < 34) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		start          <= 1'b1;
		command        <= c;
		sample_address <= a;
		sample_value   <= v;
		clip_start     <= cs;
		clip_length    <= cl;
		step           <= st;
		do @(posedge clk); while (busy);
		sb.take_command(it);
	endtask

	// Load any clip word the frame would read, then render it
	task automatic render_frame();
		int tap;
		tap = sb.unloaded_tap();
		while (tap >= 0) begin
			send_cmd(CMD_LOAD, tap, $urandom, $urandom, $urandom, $urandom);
			tap = sb.unloaded_tap();
		end
		send_cmd(CMD_RENDER, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Hold start low until every frame is in, then let the block settle
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly renders and triggers with varied clips; some stops and stray loads
	task automatic random_item();
		int r;
		logic [12:0] cl;
		logic [17:0] st;
		r = $urandom_range(99);
		if (r < 55) begin
			render_frame();
		end else if (r < 70) begin
			case ($urandom_range(19))
				0:          cl = 13'd0;
				1:          cl = 13'd1;
				2:          cl = 13'd4096;
				3, 4, 5:    cl = $urandom_range(8, 2);
				16, 17:     cl = $urandom_range(4095, 201);
				default:    cl = $urandom_range(200, 9);
			endcase
			case ($urandom_range(9))
				0:          st = 18'd0;
				1:          st = 18'h3FFFF;
				2, 3:       st = $urandom_range(8191);
				4, 5, 6:    st = $urandom_range(81920, 49152);
				7:          st = 18'h10000;
				default:    st = $urandom_range(262143);
			endcase
			send_cmd(CMD_TRIGGER, $urandom, $urandom, $urandom_range(4095), cl, st);
		end else if (r < 76) begin
			send_cmd(CMD_STOP, $urandom, $urandom, $urandom, $urandom, $urandom);
		end else begin
			send_cmd(CMD_LOAD, $urandom_range(4095), $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin : stimulus
		logic [15:0] phase_gain [PHASES];
		logic [7:0]  phase_fade [PHASES];
		int goal;
		phase_gain = '{16'd0, 16'hFFFF, 16'h8000, 16'd0, 16'd0, GAIN_RESET};
		phase_fade = '{8'd1, 8'd255, 8'd1, 8'd0, 8'd0, FADE_RESET};
		phase_gain[3] = $urandom_range(65535);
		phase_gain[4] = $urandom_range(65535);
		phase_fade[3] = $urandom_range(255, 1);
		phase_fade[4] = $urandom_range(255, 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme samples at both ends of memory, silence, wrapping clip
		send_cmd(CMD_LOAD, 12'd4094, 16'h7FFF, 12'd0, 13'd0, 18'd0);
		send_cmd(CMD_LOAD, 12'd4095, 16'h8000, 12'd0, 13'd0, 18'd0);
		send_cmd(CMD_LOAD, 12'd0, 16'h7FFF, 12'd0, 13'd0, 18'd0);
		send_cmd(CMD_LOAD, 12'd1, 16'hFFFF, 12'd0, 13'd0, 18'd0);
		send_cmd(CMD_LOAD, 12'd2, 16'h8000, 12'd0, 13'd0, 18'd0);
		send_cmd(CMD_LOAD, 12'd3, 16'h3039, 12'd0, 13'd0, 18'd0);
		render_frame();
		send_cmd(CMD_TRIGGER, 12'd0, 16'd0, 12'd4094, 13'd6, 18'h08000);
		render_frame();
		render_frame();
		// Second voice at full length and top speed, then both busy, then short clips
		send_cmd(CMD_TRIGGER, 12'd0, 16'd0, 12'd0, 13'd4096, 18'h3FFFF);
		render_frame();
		render_frame();
		send_cmd(CMD_TRIGGER, 12'd0, 16'd0, 12'd100, 13'd1, 18'h10000);
		render_frame();
		send_cmd(CMD_TRIGGER, 12'd0, 16'd0, 12'd5, 13'd0, 18'd0);
		render_frame();
		send_cmd(CMD_STOP, 12'd0, 16'd0, 12'd0, 13'd0, 18'd0);
		render_frame();
		render_frame();

		// Directed: full gain for saturation, zero fade length cuts at once
		drain();
		write_reg(CFG_GAIN, 16'hFFFF);
		write_reg(CFG_FADE, 16'h0000);
		send_cmd(CMD_TRIGGER, 12'd0, 16'd0, 12'd0, 13'd3, 18'd0);
		send_cmd(CMD_TRIGGER, 12'd0, 16'd0, 12'd4094, 13'd4, 18'h04000);
		render_frame();
		render_frame();
		send_cmd(CMD_STOP, 12'd0, 16'd0, 12'd0, 13'd0, 18'd0);
		render_frame();

		// Random phases, one register setting each; the third runs without gaps
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_reg(CFG_GAIN, phase_gain[p]);
			write_reg(CFG_FADE, {8'h00, phase_fade[p]});
			gaps_on = (p != 2);
			goal = sb.n_items + ITEMS_PER_PHASE;
			while (sb.n_items < goal) random_item();
		end
		drain();

		$display("run covered %0d items: %0d loads, %0d triggers, %0d stops, %0d frames",
			sb.n_items, sb.n_load, sb.n_trig, sb.n_stop, sb.frames);
		$display("with %0d register writes, %0d saturated frames, %0d voices faded out",
			sb.n_writes, sb.n_sat, sb.n_faded);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
